FILE: rtl/core/kmsf_pkg.sv
// Package for the maximum spanning forest block: edge entry type, controller
// operation codes, command and status structs, edge ordering function.
// No dependencies.
`default_nettype none
package kmsf_pkg;

    typedef struct packed {
        logic [15:0] wt;
        logic [9:0]  rnode;
        logic [9:0]  lnode;
    } t_edge;

    localparam int EDGE_W = 36;

    typedef logic [4:0] t_op;

    localparam t_op OP_NOP      = 5'd0;
    localparam t_op OP_LOAD     = 5'd1;
    localparam t_op OP_SORT_RDI = 5'd2;
    localparam t_op OP_SORT_CUR = 5'd3;
    localparam t_op OP_SORT_RDJ = 5'd4;
    localparam t_op OP_SORT_SHF = 5'd5;
    localparam t_op OP_SORT_PUT = 5'd6;
    localparam t_op OP_CLR      = 5'd7;
    localparam t_op OP_E_RD     = 5'd8;
    localparam t_op OP_E_FETCH  = 5'd9;
    localparam t_op OP_MOD      = 5'd10;
    localparam t_op OP_RA_RD    = 5'd11;
    localparam t_op OP_RA_CHK   = 5'd12;
    localparam t_op OP_RB_RD    = 5'd13;
    localparam t_op OP_RB_CHK   = 5'd14;
    localparam t_op OP_CMP      = 5'd15;
    localparam t_op OP_SZB      = 5'd16;
    localparam t_op OP_SZW      = 5'd17;
    localparam t_op OP_JOIN     = 5'd18;
    localparam t_op OP_FIN      = 5'd19;
    localparam t_op OP_DONE     = 5'd20;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic i_done;
        logic j_zero;
        logic first;
        logic clr_done;
        logic mod_done;
        logic at_root;
        logic same_root;
    } t_stat;

    localparam logic [1:0] REG_LEFT  = 2'd0;
    localparam logic [1:0] REG_RIGHT = 2'd1;
    localparam logic [1:0] REG_BASE  = 2'd2;

    localparam logic [15:0] BASE_COST_RST = 16'd10000;

    // heavier first, then smaller right node, then smaller left node
    function automatic logic goes_first(input t_edge a, input t_edge b);
        return {a.wt, ~a.rnode, ~a.lnode} > {b.wt, ~b.rnode, ~b.lnode};
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/kmsf_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module kmsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                        i_clk,
    input  wire                                        i_we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire [WIDTH-1:0]                            i_wdata,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/kmsf_ctrl.sv
// Sequencer for the spanning forest block: load, insertion sort, set clear,
// Kruskal pass and result hand-off. Uses kmsf_pkg; drives kmsf_dpath.
`default_nettype none
module kmsf_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire              i_in_last,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    input  kmsf_pkg::t_stat  i_stat,
    output kmsf_pkg::t_cmd   o_cmd
);
    import kmsf_pkg::*;

    localparam logic [4:0] S_LOAD = 5'd0;
    localparam logic [4:0] S_SI   = 5'd1;
    localparam logic [4:0] S_SIW  = 5'd2;
    localparam logic [4:0] S_SJ   = 5'd3;
    localparam logic [4:0] S_SJW  = 5'd4;
    localparam logic [4:0] S_CLR  = 5'd5;
    localparam logic [4:0] S_E    = 5'd6;
    localparam logic [4:0] S_EW   = 5'd7;
    localparam logic [4:0] S_MOD  = 5'd8;
    localparam logic [4:0] S_RA   = 5'd9;
    localparam logic [4:0] S_RAW  = 5'd10;
    localparam logic [4:0] S_RB   = 5'd11;
    localparam logic [4:0] S_RBW  = 5'd12;
    localparam logic [4:0] S_CMP  = 5'd13;
    localparam logic [4:0] S_SZA  = 5'd14;
    localparam logic [4:0] S_SZW  = 5'd15;
    localparam logic [4:0] S_JOIN = 5'd16;
    localparam logic [4:0] S_OUT  = 5'd17;

    logic [4:0] r_state;
    logic [4:0] n_state;

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NOP;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    if (i_in_last) n_state = S_SI;
                end
            end
            S_SI: begin
                if (i_stat.i_done) begin
                    n_state = S_CLR;
                end else begin
                    o_cmd.op = OP_SORT_RDI;
                    n_state  = S_SIW;
                end
            end
            S_SIW: begin
                o_cmd.op = OP_SORT_CUR;
                n_state  = S_SJ;
            end
            S_SJ: begin
                if (i_stat.j_zero) begin
                    o_cmd.op = OP_SORT_PUT;
                    n_state  = S_SI;
                end else begin
                    o_cmd.op = OP_SORT_RDJ;
                    n_state  = S_SJW;
                end
            end
            S_SJW: begin
                if (i_stat.first) begin
                    o_cmd.op = OP_SORT_SHF;
                    n_state  = S_SJ;
                end else begin
                    o_cmd.op = OP_SORT_PUT;
                    n_state  = S_SI;
                end
            end
            S_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_stat.clr_done) n_state = S_E;
            end
            S_E: begin
                if (i_stat.i_done) begin
                    o_cmd.op = OP_FIN;
                    n_state  = S_OUT;
                end else begin
                    o_cmd.op = OP_E_RD;
                    n_state  = S_EW;
                end
            end
            S_EW: begin
                o_cmd.op = OP_E_FETCH;
                n_state  = S_MOD;
            end
            S_MOD: begin
                o_cmd.op = OP_MOD;
                if (i_stat.mod_done) n_state = S_RA;
            end
            S_RA: begin
                o_cmd.op = OP_RA_RD;
                n_state  = S_RAW;
            end
            S_RAW: begin
                o_cmd.op = OP_RA_CHK;
                n_state  = i_stat.at_root ? S_RB : S_RA;
            end
            S_RB: begin
                o_cmd.op = OP_RB_RD;
                n_state  = S_RBW;
            end
            S_RBW: begin
                o_cmd.op = OP_RB_CHK;
                n_state  = i_stat.at_root ? S_CMP : S_RB;
            end
            S_CMP: begin
                o_cmd.op = OP_CMP;
                n_state  = i_stat.same_root ? S_E : S_SZA;
            end
            S_SZA: begin
                o_cmd.op = OP_SZB;
                n_state  = S_SZW;
            end
            S_SZW: begin
                o_cmd.op = OP_SZW;
                n_state  = S_JOIN;
            end
            S_JOIN: begin
                o_cmd.op = OP_JOIN;
                n_state  = S_E;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    o_cmd.op = OP_DONE;
                    n_state  = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/kmsf_dpath.sv
// Datapath for the spanning forest block: edge store, parent and size tables,
// counters, root registers and cost arithmetic. Uses kmsf_pkg and kmsf_ram.
`default_nettype none
module kmsf_dpath #(
    parameter int NODE_COUNT = 2048,
    parameter int EDGE_COUNT = 1024
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  kmsf_pkg::t_cmd   i_cmd,
    output kmsf_pkg::t_stat  o_stat,
    input  wire [35:0]       i_edge,
    input  wire [10:0]       i_left_count,
    input  wire [10:0]       i_right_count,
    input  wire [15:0]       i_base_cost,
    output logic [47:0]      o_total_cost,
    output logic             o_overflow
);
    import kmsf_pkg::*;

    localparam int EAW = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT) : 1;
    localparam int CW  = $clog2(EDGE_COUNT + 1);
    localparam int NW  = $clog2(NODE_COUNT);
    localparam int ZW  = $clog2(NODE_COUNT + 1);
    localparam int VW  = (NW > 12) ? NW : 12;

    logic [CW-1:0] r_cnt, r_i, r_j;
    logic          r_ovf;
    logic [NW-1:0] r_k;
    t_edge         r_cur;
    logic [VW-1:0] r_a, r_b;
    logic [15:0]   r_w;
    logic [NW-1:0] r_n, r_ra, r_rb;
    logic [ZW-1:0] r_sa, r_sb;
    logic [47:0]   r_kept, r_prod, r_cost;

    logic            e_we;
    logic [EAW-1:0]  e_waddr, e_raddr;
    t_edge           e_wdata, e_rdata;
    logic [EDGE_W-1:0] e_rbits;
    logic            p_we;
    logic [NW-1:0]   p_waddr, p_wdata, p_raddr, p_rdata;
    logic            z_we;
    logic [NW-1:0]   z_waddr, z_raddr;
    logic [ZW-1:0]   z_wdata, z_rdata;
    logic [CW-1:0]   jm1;
    logic            full, a_big, b_big, swap;
    logic [ZW-1:0]   sz_sum;
    logic [11:0]     node_sum;
    logic [27:0]     prod_w;

    assign e_rdata = t_edge'(e_rbits);
    assign jm1     = r_j - 1'b1;
    assign full    = (r_cnt == CW'(EDGE_COUNT));
    assign a_big   = (32'(r_a) >= 32'(NODE_COUNT));
    assign b_big   = (32'(r_b) >= 32'(NODE_COUNT));
    assign swap    = (r_sb > r_sa);
    assign sz_sum  = r_sa + r_sb;
    assign node_sum = 12'(i_left_count) + 12'(i_right_count);
    assign prod_w   = node_sum * i_base_cost;

    assign o_stat.i_done    = (r_i >= r_cnt);
    assign o_stat.j_zero    = (r_j == '0);
    assign o_stat.first     = goes_first(r_cur, e_rdata);
    assign o_stat.clr_done  = (r_k == NW'(NODE_COUNT - 1));
    assign o_stat.mod_done  = !a_big && !b_big;
    assign o_stat.at_root   = (p_rdata == r_n);
    assign o_stat.same_root = (r_ra == r_rb);

    always_comb begin
        e_we    = 1'b0;
        e_waddr = r_cnt[EAW-1:0];
        e_wdata = t_edge'(i_edge);
        e_raddr = r_i[EAW-1:0];
        p_we    = 1'b0;
        p_waddr = r_k;
        p_wdata = r_k;
        p_raddr = r_n;
        z_we    = 1'b0;
        z_waddr = r_k;
        z_wdata = ZW'(1);
        z_raddr = r_ra;
        case (i_cmd.op)
            OP_LOAD: e_we = !full;
            OP_SORT_RDJ: e_raddr = jm1[EAW-1:0];
            OP_SORT_SHF: begin
                e_we    = 1'b1;
                e_waddr = r_j[EAW-1:0];
                e_wdata = e_rdata;
            end
            OP_SORT_PUT: begin
                e_we    = 1'b1;
                e_waddr = r_j[EAW-1:0];
                e_wdata = r_cur;
            end
            OP_CLR: begin
                p_we = 1'b1;
                z_we = 1'b1;
            end
            OP_SZB: z_raddr = r_rb;
            OP_JOIN: begin
                p_we    = 1'b1;
                z_we    = 1'b1;
                p_waddr = swap ? r_ra : r_rb;
                p_wdata = swap ? r_rb : r_ra;
                z_waddr = swap ? r_rb : r_ra;
                z_wdata = sz_sum;
            end
            default: begin
            end
        endcase
    end

    kmsf_ram #(.WIDTH(EDGE_W), .DEPTH(EDGE_COUNT)) u_edge_ram (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rbits)
    );
    kmsf_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_parent_ram (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(p_rdata)
    );
    kmsf_ram #(.WIDTH(ZW), .DEPTH(NODE_COUNT)) u_size_ram (
        .i_clk(i_clk), .i_we(z_we), .i_waddr(z_waddr), .i_wdata(z_wdata),
        .i_raddr(z_raddr), .o_rdata(z_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
            r_k   <= '0;
            r_i   <= '0;
            r_j   <= '0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    if (full) r_ovf <= 1'b1;
                    else      r_cnt <= r_cnt + 1'b1;
                    r_i <= CW'(1);
                end
                OP_SORT_CUR: r_j <= r_i;
                OP_SORT_SHF: r_j <= jm1;
                OP_SORT_PUT: r_i <= r_i + 1'b1;
                OP_CLR: begin
                    r_k <= o_stat.clr_done ? '0 : r_k + 1'b1;
                    r_i <= '0;
                end
                OP_CMP:  if (o_stat.same_root) r_i <= r_i + 1'b1;
                OP_JOIN: r_i <= r_i + 1'b1;
                OP_DONE: begin
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 48'(prod_w);
        case (i_cmd.op)
            OP_SORT_CUR: r_cur <= e_rdata;
            OP_CLR:      r_kept <= '0;
            OP_E_FETCH: begin
                r_a <= VW'(e_rdata.lnode);
                r_b <= VW'(e_rdata.rnode) + VW'(i_left_count);
                r_w <= e_rdata.wt;
            end
            OP_MOD: begin
                if (a_big) r_a <= r_a - VW'(NODE_COUNT);
                if (b_big) r_b <= r_b - VW'(NODE_COUNT);
                r_n <= r_a[NW-1:0];
            end
            OP_RA_CHK: begin
                if (o_stat.at_root) begin
                    r_ra <= r_n;
                    r_n  <= r_b[NW-1:0];
                end else begin
                    r_n <= p_rdata;
                end
            end
            OP_RB_CHK: begin
                if (o_stat.at_root) r_rb <= r_n;
                else                r_n  <= p_rdata;
            end
            OP_CMP: if (!o_stat.same_root) r_kept <= r_kept + 48'(r_w);
            OP_SZB: r_sa <= z_rdata;
            OP_SZW: r_sb <= z_rdata;
            OP_FIN: r_cost <= r_prod - r_kept;
            default: begin
            end
        endcase
    end

    assign o_total_cost = r_cost;
    assign o_overflow   = r_ovf;
endmodule
`default_nettype wire

FILE: rtl/core/kruskal_max_spanning_forest.sv
// Top level of the maximum spanning forest block: stream ports, config
// registers, controller and datapath. Uses kmsf_pkg, kmsf_ctrl, kmsf_dpath.
//
// Edges are taken one per cycle until the request marked tlast; the block
// then works on the batch alone and takes no input until its one result has
// been taken. Per batch of stored edges: an insertion sort over the edge
// store, with one shift step for each earlier edge that the current one
// passes (a batch already in descending order needs no shift steps), then a
// clearing pass over all NODE_COUNT entries of the parent and size tables,
// then per edge the modulo steps that bring each node index into the table,
// two root walks that follow parent links, and a join of the two sets when
// the roots differ; last the result is presented. Averaged over the edges,
// small batches are dominated by the clearing pass and large unordered ones
// by the sort.
`default_nettype none
module kruskal_max_spanning_forest #(
    parameter int NODE_COUNT = 2048,
    parameter int EDGE_COUNT = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [1:0]   i_cfg_addr,
    input  wire [15:0]  i_cfg_wdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [39:0]  s_axis_tdata,   // left_node[9:0], right_node[19:10], weight[35:20]
    input  wire         s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,   // total_cost[47:0]
    output logic        m_axis_tuser    // overflow
);
    import kmsf_pkg::*;

    logic [10:0] r_left_count, r_right_count;
    logic [15:0] r_base_cost;
    t_cmd        cmd;
    t_stat       stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_count  <= '0;
            r_right_count <= '0;
            r_base_cost   <= BASE_COST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_LEFT:  r_left_count  <= i_cfg_wdata[10:0];
                REG_RIGHT: r_right_count <= i_cfg_wdata[10:0];
                REG_BASE:  r_base_cost   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    kmsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    kmsf_dpath #(.NODE_COUNT(NODE_COUNT), .EDGE_COUNT(EDGE_COUNT)) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_edge        ({s_axis_tdata[35:20], s_axis_tdata[19:10], s_axis_tdata[9:0]}),
        .i_left_count  (r_left_count),
        .i_right_count (r_right_count),
        .i_base_cost   (r_base_cost),
        .o_total_cost  (m_axis_tdata),
        .o_overflow    (m_axis_tuser)
    );
endmodule
`default_nettype wire

FILE: rtl/core/kmsf_checker.sv
// Port-level checks for the spanning forest block, bound to the top level.
// No dependencies beyond the top-level ports.
`default_nettype none
module kmsf_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        s_axis_tlast,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [47:0] m_axis_tdata,
    input wire        m_axis_tuser
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input open while result pending");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input open after last request");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");
endmodule

bind kruskal_max_spanning_forest kmsf_checker u_kmsf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

FILE: tb/kruskal_max_spanning_forest_tb.sv
// Testbench for kruskal_max_spanning_forest: edge batches in, forest cost out.
// A scoreboard class predicts each batch cost; depends on kmsf_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module kruskal_max_spanning_forest_tb;
    import kmsf_pkg::*;

    localparam int NODES = 2048;
    localparam int EDGES = 1024;

    typedef struct {
        logic [47:0] cost;
        logic        ovf;
    } t_forest_result;

    class forest_scoreboard;
        logic [10:0]    left_cnt;
        logic [10:0]    right_cnt;
        logic [15:0]    base;
        t_edge          batch [EDGES];
        int             batch_len;
        logic           ovf;
        logic [10:0]    parent [NODES];
        logic [11:0]    set_size [NODES];
        t_forest_result pending_costs [$];
        int             errors;
        int             results_seen;
        int             ovf_seen;

        function new();
            left_cnt = '0;
            right_cnt = '0;
            base = 16'd10000;
            batch_len = 0;
            ovf = 1'b0;
            errors = 0;
            results_seen = 0;
            ovf_seen = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_LEFT:  left_cnt = val[10:0];
                REG_RIGHT: right_cnt = val[10:0];
                REG_BASE:  base = val;
                default: ;
            endcase
        endfunction

        function logic [10:0] find_root(logic [10:0] n);
            int steps;
            steps = 0;
            while (parent[n] != n && steps < NODES) begin
                n = parent[n];
                steps++;
            end
            return n;
        endfunction

        function bit heavier(t_edge a, t_edge b);
            if (a.wt != b.wt) return a.wt > b.wt;
            if (a.rnode != b.rnode) return a.rnode < b.rnode;
            return a.lnode < b.lnode;
        endfunction

        function void note_edge(t_edge e, logic last);
            t_forest_result res;
            t_edge cur;
            logic [47:0] kept;
            logic [10:0] ra, rb, tmp;
            int j;
            if (batch_len < EDGES) begin
                batch[batch_len] = e;
                batch_len++;
            end else begin
                ovf = 1'b1;
            end
            if (!last) return;
            for (int i = 1; i < batch_len; i++) begin
                cur = batch[i];
                j = i;
                while (j > 0 && heavier(cur, batch[j-1])) begin
                    batch[j] = batch[j-1];
                    j--;
                end
                batch[j] = cur;
            end
            for (int i = 0; i < NODES; i++) begin
                parent[i] = 11'(i);
                set_size[i] = 12'd1;
            end
            kept = '0;
            for (int i = 0; i < batch_len; i++) begin
                ra = find_root(11'(batch[i].lnode));
                rb = find_root(11'(batch[i].rnode) + left_cnt);
                if (ra != rb) begin
                    kept += 48'(batch[i].wt);
                    if (set_size[rb] > set_size[ra]) begin
                        tmp = ra;
                        ra = rb;
                        rb = tmp;
                    end
                    parent[rb] = ra;
                    set_size[ra] += set_size[rb];
                end
            end
            res.cost = (48'(left_cnt) + 48'(right_cnt)) * 48'(base) - kept;
            res.ovf = ovf;
            pending_costs.push_back(res);
            batch_len = 0;
            ovf = 1'b0;
        endfunction

        function void check_result(logic [47:0] cost, logic ovf_out);
            t_forest_result exp_res;
            results_seen++;
            if (pending_costs.size() == 0) begin
                $error("unexpected result: total_cost %h overflow %b", cost, ovf_out);
                errors++;
                return;
            end
            exp_res = pending_costs.pop_front();
            if (exp_res.ovf) ovf_seen++;
            if (cost !== exp_res.cost) begin
                $error("total_cost: expected %h actual %h", exp_res.cost, cost);
                errors++;
            end
            if (ovf_out !== exp_res.ovf) begin
                $error("overflow: expected %b actual %b", exp_res.ovf, ovf_out);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [15:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;

    forest_scoreboard sb;
    bit quiet;
    int edges_sent;
    int stall_left;

    kruskal_max_spanning_forest i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // result side: take results, stall in bursts
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 18) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_edge(logic [9:0] l, logic [9:0] r, logic [15:0] w, logic last);
        t_edge e;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        e.lnode = l;
        e.rnode = r;
        e.wt = w;
        s_axis_tdata <= {4'b0, w, r, l};
        s_axis_tlast <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_edge(e, last);
        edges_sent++;
    endtask

    task automatic drain();
        while (sb.pending_costs.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic set_counts(logic [15:0] l, logic [15:0] r, logic [15:0] b);
        s_axis_tvalid <= 1'b0;
        drain();
        write_reg(REG_LEFT, l);
        write_reg(REG_RIGHT, r);
        write_reg(REG_BASE, b);
    endtask

    // random batch; narrow modes force ties, cycles and deep unions
    task automatic random_batch(int len);
        bit narrow_nodes;
        bit narrow_wt;
        logic [9:0] l, r;
        logic [15:0] w;
        narrow_nodes = $urandom_range(0, 2) != 0;
        narrow_wt = $urandom_range(0, 1);
        for (int i = 0; i < len; i++) begin
            l = narrow_nodes ? 10'($urandom_range(0, 7)) : 10'($urandom_range(0, 1023));
            r = narrow_nodes ? 10'($urandom_range(0, 7)) : 10'($urandom_range(0, 1023));
            w = narrow_wt ? 16'($urandom_range(0, 15)) : 16'($urandom_range(0, 65535));
            send_edge(l, r, w, i == len - 1);
        end
    endtask

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        sb = new();
        quiet = 1'b0;
        edges_sent = 0;
        stall_left = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: zero nodes, so every edge joins node ids directly
        send_edge(10'd0, 10'd1, 16'd5, 1'b1);
        send_edge(10'd3, 10'd3, 16'd7, 1'b1);

        set_counts(16'd4, 16'd5, 16'd100);
        // ties by weight, then right, then left; cycle edge; equal sizes
        send_edge(10'd0, 10'd0, 16'd50, 1'b0);
        send_edge(10'd1, 10'd0, 16'd50, 1'b0);
        send_edge(10'd0, 10'd1, 16'd50, 1'b0);
        send_edge(10'd1, 10'd1, 16'd50, 1'b0);
        send_edge(10'd2, 10'd3, 16'd0, 1'b0);
        send_edge(10'd3, 10'd2, 16'd65535, 1'b1);

        // maximum indices and wrap past the node table
        set_counts(16'd2047, 16'd2047, 16'd65535);
        send_edge(10'd1023, 10'd1023, 16'd65535, 1'b0);
        send_edge(10'd0, 10'd1, 16'd1, 1'b0);
        send_edge(10'd1023, 10'd0, 16'd0, 1'b1);

        // zero base cost gives a negative total
        set_counts(16'd1024, 16'd1024, 16'd0);
        send_edge(10'd5, 10'd6, 16'd65535, 1'b0);
        send_edge(10'd7, 10'd8, 16'd40000, 1'b1);

        // store overflow; descending weights keep the sort short
        set_counts(16'd1024, 16'd0, 16'd10000);
        for (int i = 0; i < EDGES + 6; i++)
            send_edge(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                      16'(60000 - i * 50), i == EDGES + 5);

        while (edges_sent < 1950) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: set_counts(16'($urandom_range(0, 16)), 16'($urandom_range(0, 16)),
                                  16'($urandom_range(0, 65535)));
                    1: set_counts(16'($urandom_range(0, 2047)), 16'($urandom_range(0, 2047)),
                                  16'($urandom_range(0, 65535)));
                    2: set_counts(16'd0, 16'd0, 16'd0);
                    default: set_counts(16'd2047, 16'd2047, 16'hffff);
                endcase
            end
            if (edges_sent > 1750) quiet = 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                s_axis_tvalid <= 1'b0;
                drain();
            end
            random_batch($urandom_range(1, 40));
        end
        s_axis_tvalid <= 1'b0;
        drain();
        repeat (100) @(posedge i_clk);

        $display("ran %0d edges into %0d batch results (%0d with store overflow)",
                 edges_sent, sb.results_seen, sb.ovf_seen);
        if (sb.errors == 0 && sb.pending_costs.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
rtl/core/kmsf_pkg.sv
rtl/core/kmsf_ram.sv
rtl/core/kmsf_ctrl.sv
rtl/core/kmsf_dpath.sv
rtl/core/kruskal_max_spanning_forest.sv
rtl/core/kmsf_checker.sv
tb/kruskal_max_spanning_forest_tb.sv
